// ----- rtl/grid_distance_heuristic_macros.svh -----
// assertion macros for the grid distance heuristic checker
`ifndef GRID_DISTANCE_HEURISTIC_MACROS_SVH
`define GRID_DISTANCE_HEURISTIC_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define GDH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("grid distance heuristic check failed");

// consequent must hold a fixed number of cycles after the antecedent
`define GDH_ASSERT_LAT(lbl, ante, lat, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##lat (cons)) \
    else $error("grid distance heuristic check failed");

`endif

// ----- rtl/gdh_pkg.sv -----
// shared constants, types and the square root digit step of the grid distance heuristic
`timescale 1ns / 1ps
`default_nettype none

package gdh_pkg;

  localparam int COORD_BITS    = 12;
  localparam int FRAC_BITS     = 8;
  localparam int MODE_BITS     = 3;
  localparam int OUT_BITS      = COORD_BITS + 1 + FRAC_BITS;
  localparam int SQ_BITS       = 2 * COORD_BITS;
  localparam int SUM_BITS      = SQ_BITS + 1;
  localparam int DIG_PER_STAGE = 3;
  localparam int SQRT_STAGES   = (OUT_BITS + DIG_PER_STAGE - 1) / DIG_PER_STAGE;
  localparam int NDIG          = SQRT_STAGES * DIG_PER_STAGE;
  localparam int RAD_BITS      = 2 * NDIG;
  localparam int REM_BITS      = NDIG + 2;
  // start beat to result strobe: three front stages, the root stages, the output register
  localparam int LATENCY       = SQRT_STAGES + 4;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_ZERO      = 3'd0,
    MODE_EUCLID    = 3'd1,
    MODE_OCTILE    = 3'd2,
    MODE_MANHATTAN = 3'd3,
    MODE_CHEBYSHEV = 3'd4
  } gdh_mode_e;

  // what travels beside the radicand down to the output adder
  typedef struct packed {
    logic                use_root;
    logic [OUT_BITS-1:0] lin;
  } gdh_side_t;

  typedef struct packed {
    logic [REM_BITS-1:0] rem;
    logic [NDIG-1:0]     root;
  } gdh_sq_t;

  // one restoring digit of the integer square root
  function automatic gdh_sq_t gdh_sqrt_step(gdh_sq_t cur, logic [1:0] pair);
    gdh_sq_t             nxt;
    logic [REM_BITS-1:0] shifted;
    logic [REM_BITS-1:0] trial;
    shifted = {cur.rem[REM_BITS-3:0], pair};
    trial   = {cur.root, 2'b01};
    if (shifted >= trial) begin
      nxt.rem  = shifted - trial;
      nxt.root = {cur.root[NDIG-2:0], 1'b1};
    end else begin
      nxt.rem  = shifted;
      nxt.root = {cur.root[NDIG-2:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/gdh_front.sv -----
// front stages: deltas and metric select, squaring, radicand sum
`timescale 1ns / 1ps
`default_nettype none

module gdh_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  input  wire logic [gdh_pkg::COORD_BITS-1:0] from_row_i,
  input  wire logic [gdh_pkg::COORD_BITS-1:0] from_col_i,
  input  wire logic [gdh_pkg::COORD_BITS-1:0] to_row_i,
  input  wire logic [gdh_pkg::COORD_BITS-1:0] to_col_i,
  input  wire logic [gdh_pkg::MODE_BITS-1:0]  mode_i,
  output logic                                out_valid_o,
  output logic [gdh_pkg::RAD_BITS-1:0]        rad_o,
  output gdh_pkg::gdh_side_t                  side_o
);
  import gdh_pkg::*;

  logic [COORD_BITS-1:0] dr, dc, lo, hi;
  logic [COORD_BITS-1:0] op_a_d, op_b_d;
  gdh_side_t             side_d;

  logic                  a_vld_q;
  logic [COORD_BITS-1:0] a_op_a_q, a_op_b_q;
  gdh_side_t             a_side_q;

  logic                  b_vld_q;
  logic [SQ_BITS-1:0]    b_sq_a_q, b_sq_b_q;
  gdh_side_t             b_side_q;

  logic                  c_vld_q;
  logic [RAD_BITS-1:0]   c_rad_q;
  gdh_side_t             c_side_q;

  // stage a: absolute deltas, ordering, linear term
  always_comb begin
    dr = (from_row_i >= to_row_i) ? from_row_i - to_row_i : to_row_i - from_row_i;
    dc = (from_col_i >= to_col_i) ? from_col_i - to_col_i : to_col_i - from_col_i;
    lo = (dr < dc) ? dr : dc;
    hi = (dr < dc) ? dc : dr;
  end

  always_comb begin
    op_a_d          = '0;
    op_b_d          = '0;
    side_d.use_root = 1'b0;
    side_d.lin      = '0;
    case (gdh_mode_e'(mode_i))
      MODE_EUCLID: begin
        op_a_d          = dr;
        op_b_d          = dc;
        side_d.use_root = 1'b1;
      end
      MODE_OCTILE: begin
        op_a_d          = lo;
        op_b_d          = lo;
        side_d.use_root = 1'b1;
        side_d.lin      = OUT_BITS'(hi - lo) << FRAC_BITS;
      end
      MODE_MANHATTAN: begin
        side_d.lin = (OUT_BITS'(dr) + OUT_BITS'(dc)) << FRAC_BITS;
      end
      MODE_CHEBYSHEV: begin
        side_d.lin = OUT_BITS'(hi) << FRAC_BITS;
      end
      default: begin
        side_d.lin = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      a_vld_q <= in_valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_op_a_q <= op_a_d;
    a_op_b_q <= op_b_d;
    a_side_q <= side_d;
    // stage b: squares
    b_sq_a_q <= SQ_BITS'(a_op_a_q) * SQ_BITS'(a_op_a_q);
    b_sq_b_q <= SQ_BITS'(a_op_b_q) * SQ_BITS'(a_op_b_q);
    b_side_q <= a_side_q;
    // stage c: sum, scaled for the fraction bits of the root
    c_rad_q  <= RAD_BITS'(SUM_BITS'(b_sq_a_q) + SUM_BITS'(b_sq_b_q)) << (2 * FRAC_BITS);
    c_side_q <= b_side_q;
  end

  assign out_valid_o = c_vld_q;
  assign rad_o       = c_rad_q;
  assign side_o      = c_side_q;

endmodule

`default_nettype wire

// ----- rtl/gdh_sqrt.sv -----
// pipelined digit-by-digit integer square root, a few digits per stage
`timescale 1ns / 1ps
`default_nettype none

module gdh_sqrt (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  input  wire logic [gdh_pkg::RAD_BITS-1:0] rad_i,
  input  wire gdh_pkg::gdh_side_t           side_i,
  output logic                              out_valid_o,
  output logic [gdh_pkg::OUT_BITS-1:0]      root_o,
  output gdh_pkg::gdh_side_t                side_o
);
  import gdh_pkg::*;

  logic                vld_q  [SQRT_STAGES];
  logic [RAD_BITS-1:0] rad_q  [SQRT_STAGES];
  gdh_sq_t             acc_q  [SQRT_STAGES];
  gdh_side_t           side_q [SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    logic                vld_in;
    logic [RAD_BITS-1:0] rad_in;
    gdh_sq_t             acc_in;
    gdh_side_t           side_in;
    gdh_sq_t             acc_d;

    if (s == 0) begin : g_first
      assign vld_in  = in_valid_i;
      assign rad_in  = rad_i;
      assign acc_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign acc_in  = acc_q[s-1];
      assign side_in = side_q[s-1];
    end

    // digits from the top pair down
    always_comb begin
      acc_d = acc_in;
      for (int i = 0; i < DIG_PER_STAGE; i++) begin
        acc_d = gdh_sqrt_step(acc_d, rad_in[2 * (NDIG - 1 - s * DIG_PER_STAGE - i) +: 2]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[s]  <= rad_in;
      acc_q[s]  <= acc_d;
      side_q[s] <= side_in;
    end
  end

  assign out_valid_o = vld_q[SQRT_STAGES-1];
  assign root_o      = acc_q[SQRT_STAGES-1].root[OUT_BITS-1:0];
  assign side_o      = side_q[SQRT_STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/grid_distance_heuristic.sv -----
// top level of the grid distance heuristic pipeline
`timescale 1ns / 1ps
`default_nettype none

// usage
//   command channel: a cell pair is taken at a rising edge with start high and busy low.
//   busy is low whenever reset is released, so one pair can be taken in every cycle.
//   result channel: done_o is high for exactly one cycle with distance_o valid in that
//   cycle; the receiver cannot hold results off, so nothing upstream ever waits.
//   config channel: metric_mode is written by a cfg_valid_i / cfg_ready_o beat; the user must
//   write it only while no pair is in flight, which the block itself does not enforce;
//   cfg_ready_o is high whenever reset is released.
// pipeline and throughput
//   from the start beat to the done_o beat a pair passes three front stages (deltas, squares,
//   radicand), one stage per three root digits of the square root pipeline, then the output
//   register; distance_o is valid on the ports while done_o is high. One pair per cycle, set
//   by the fully pipelined root unit.
// reset
//   rst_ni clears every valid bit and sets metric_mode to the zero heuristic; pairs in flight
//   are dropped and no result strobe follows.
module grid_distance_heuristic (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [gdh_pkg::COORD_BITS-1:0] from_row_i,
  input  wire logic [gdh_pkg::COORD_BITS-1:0] from_col_i,
  input  wire logic [gdh_pkg::COORD_BITS-1:0] to_row_i,
  input  wire logic [gdh_pkg::COORD_BITS-1:0] to_col_i,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [gdh_pkg::MODE_BITS-1:0]  cfg_data_i,
  output logic                                done_o,
  output logic [gdh_pkg::OUT_BITS-1:0]        distance_o
);
  import gdh_pkg::*;

  logic [MODE_BITS-1:0] mode_q;
  logic                 front_vld;
  logic [RAD_BITS-1:0]  front_rad;
  gdh_side_t            front_side;
  logic                 root_vld;
  logic [OUT_BITS-1:0]  root;
  gdh_side_t            root_side;
  logic [OUT_BITS-1:0]  distance_d;
  logic [OUT_BITS-1:0]  distance_q;
  logic                 done_q;

  // no backpressure anywhere: only reset holds the channels off
  assign busy        = ~rst_ni;
  assign cfg_ready_o = rst_ni;

  // metric register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ZERO;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  gdh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (start && !busy),
    .from_row_i  (from_row_i),
    .from_col_i  (from_col_i),
    .to_row_i    (to_row_i),
    .to_col_i    (to_col_i),
    .mode_i      (mode_q),
    .out_valid_o (front_vld),
    .rad_o       (front_rad),
    .side_o      (front_side)
  );

  gdh_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_vld),
    .rad_i       (front_rad),
    .side_i      (front_side),
    .out_valid_o (root_vld),
    .root_o      (root),
    .side_o      (root_side)
  );

  // linear term plus the root when the metric uses one; wraps to the output width
  assign distance_d = root_side.lin + (root_side.use_root ? root : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= root_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    distance_q <= distance_d;
  end

  assign done_o     = done_q;
  assign distance_o = distance_q;

endmodule

`default_nettype wire

// ----- rtl/grid_distance_heuristic_chk.sv -----
// port-level checker for the grid distance heuristic, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "grid_distance_heuristic_macros.svh"

module grid_distance_heuristic_chk (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           start,
  input wire logic                           busy,
  input wire logic                           cfg_valid_i,
  input wire logic                           cfg_ready_o,
  input wire logic [gdh_pkg::MODE_BITS-1:0]  cfg_data_i,
  input wire logic                           done_o,
  input wire logic [gdh_pkg::OUT_BITS-1:0]   distance_o
);
  import gdh_pkg::*;

  localparam logic [OUT_BITS-1:0] FracMask = OUT_BITS'((1 << FRAC_BITS) - 1);

  logic [MODE_BITS-1:0] chk_mode_q;
  logic                 mode_zero;
  logic                 mode_whole;

  // shadow of the metric register as seen on the config beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_mode_q <= MODE_ZERO;
    end else if (cfg_valid_i && cfg_ready_o) begin
      chk_mode_q <= cfg_data_i;
    end
  end

  assign mode_zero  = (chk_mode_q == MODE_ZERO) || (chk_mode_q > MODE_CHEBYSHEV);
  assign mode_whole = (chk_mode_q == MODE_MANHATTAN) || (chk_mode_q == MODE_CHEBYSHEV);

  `GDH_ASSERT_LAT(a_result_follows, start && !busy, LATENCY, done_o)
  `GDH_ASSERT_NOW(a_no_extra_result, done_o, $past(start && !busy, LATENCY))
  `GDH_ASSERT_NOW(a_zero_metric, done_o && mode_zero, distance_o == '0)
  `GDH_ASSERT_NOW(a_whole_metric, done_o && mode_whole, (distance_o & FracMask) == '0)

endmodule

bind grid_distance_heuristic grid_distance_heuristic_chk u_chk (.*);

`default_nettype wire
